FILE: rtl/fbfa_pkg.sv
// shared types, constants and helpers for the free list block allocator
`timescale 1ns / 1ps

package fbfa_pkg;

  localparam int MAX_BLOCKS   = 256;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = 9;
  localparam int BB_W         = 13;
  localparam int OFF_W        = 20;
  localparam int PROD_W       = IDX_W + BB_W;
  localparam int ALIGN_BYTES  = 8;
  localparam int HEADER_BYTES = 8;
  localparam int MAX_BB       = 4096;
  localparam int CNT_MAX      = (1 << CNT_W) - 1;
  localparam int CFG_W        = 32;
  localparam int ADDR_W       = 3;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_INIT = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  typedef struct packed {
    logic accept;
    logic sweep_we;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic init_empty;
    logic sweep_last;
    logic out_free;
  } status_t;

  function automatic logic [BB_W-1:0] stride_bytes(input logic [BB_W-1:0] bb);
    logic [BB_W-1:0] clamped;
    logic [BB_W-1:0] rounded;
    clamped = (bb > BB_W'(MAX_BB)) ? BB_W'(MAX_BB) : bb;
    rounded = (clamped + BB_W'(ALIGN_BYTES - 1)) & ~BB_W'(ALIGN_BYTES - 1);
    return rounded + BB_W'(HEADER_BYTES);
  endfunction

  function automatic logic [CNT_W-1:0] init_count(input logic [CNT_W-1:0] bc);
    return (bc > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : bc;
  endfunction

endpackage

FILE: rtl/fbfa_ram.sv
// generic single port write, registered read ram
`timescale 1ns / 1ps

module fbfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/fbfa_ctrl.sv
// controller state machine for the free list allocator
`timescale 1ns / 1ps

module fbfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_opcode,
  input  fbfa_pkg::status_t status,
  output logic              in_stall,
  output fbfa_pkg::cmd_t    cmd
);

  fbfa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbfa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.accept   = 1'b0;
    cmd.sweep_we = 1'b0;
    cmd.commit   = 1'b0;
    in_stall     = 1'b1;
    case (state_r)
      fbfa_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_opcode == fbfa_pkg::OP_INIT && !status.init_empty) begin
            state_nxt = fbfa_pkg::S_INIT;
          end else begin
            state_nxt = fbfa_pkg::S_FIN;
          end
        end
      end
      fbfa_pkg::S_INIT: begin
        cmd.sweep_we = 1'b1;
        if (status.sweep_last) begin
          state_nxt = fbfa_pkg::S_FIN;
        end
      end
      fbfa_pkg::S_FIN: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = fbfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fbfa_pkg::S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> state_r == fbfa_pkg::S_IDLE && !cmd.commit && !cmd.sweep_we)
    else $error("accept outside idle");
  a_init_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && in_opcode == fbfa_pkg::OP_INIT && !status.init_empty |=> cmd.sweep_we)
    else $error("init did not start sweep");
  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> !in_stall)
    else $error("no return to idle after commit");
`endif

endmodule

FILE: rtl/fbfa_dp.sv
// datapath: head, counter, next table, offset math and result register
`timescale 1ns / 1ps

module fbfa_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fbfa_pkg::cmd_t                 cmd,
  output fbfa_pkg::status_t              status,
  input  logic [1:0]                     in_opcode,
  input  logic [fbfa_pkg::IDX_W-1:0]     in_free_index,
  input  logic [fbfa_pkg::CNT_W-1:0]     block_count,
  input  logic [fbfa_pkg::BB_W-1:0]      block_bytes,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_op_ok,
  output logic [fbfa_pkg::IDX_W-1:0]     out_block_index,
  output logic [fbfa_pkg::OFF_W-1:0]     out_byte_offset,
  output logic [fbfa_pkg::CNT_W-1:0]     out_free_count
);

  localparam int IW = fbfa_pkg::IDX_W;
  localparam int CW = fbfa_pkg::CNT_W;
  localparam int PW = fbfa_pkg::PROD_W;
  localparam int OW = fbfa_pkg::OFF_W;

  logic [1:0]    op_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] sweep_r;
  logic          out_valid_r;
  logic          ok_r, ok_nxt;
  logic [IW-1:0] bidx_r, bidx_nxt;
  logic [OW-1:0] off_r, off_nxt;
  logic [CW-1:0] fcnt_r;

  logic [CW-1:0]              init_n;
  logic [CW-1:0]              sweep_inc;
  logic [fbfa_pkg::BB_W-1:0]  stride;
  logic [PW-1:0]              offset_full;
  logic                       ram_we;
  logic [IW-1:0]              ram_waddr;
  logic [IW-1:0]              ram_wdata;
  logic [IW-1:0]              ram_rdata;

  assign init_n      = fbfa_pkg::init_count(block_count);
  assign sweep_inc   = sweep_r + CW'(1);
  assign stride      = fbfa_pkg::stride_bytes(block_bytes);
  assign offset_full = PW'(head_r) * PW'(stride) + PW'(fbfa_pkg::HEADER_BYTES);

  assign status.init_empty = (init_n == '0);
  assign status.sweep_last = (sweep_inc == init_n);
  assign status.out_free   = !out_valid_r || !out_stall;

  assign ram_we    = cmd.sweep_we || (cmd.commit && op_r == fbfa_pkg::OP_FREE);
  assign ram_waddr = cmd.sweep_we ? sweep_r[IW-1:0] : idx_r;
  assign ram_wdata = cmd.sweep_we ? sweep_inc[IW-1:0] : head_r;

  fbfa_ram #(
    .WIDTH (IW),
    .DEPTH (fbfa_pkg::MAX_BLOCKS)
  ) u_next_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    ok_nxt    = 1'b0;
    bidx_nxt  = '0;
    off_nxt   = '0;
    case (op_r)
      fbfa_pkg::OP_ALLOC: begin
        if (count_r != '0) begin
          ok_nxt    = 1'b1;
          bidx_nxt  = head_r;
          off_nxt   = offset_full[OW-1:0];
          head_nxt  = ram_rdata;
          count_nxt = count_r - CW'(1);
        end
      end
      fbfa_pkg::OP_FREE: begin
        ok_nxt   = 1'b1;
        head_nxt = idx_r;
        if (count_r != CW'(fbfa_pkg::CNT_MAX)) begin
          count_nxt = count_r + CW'(1);
        end
      end
      fbfa_pkg::OP_INIT: begin
        ok_nxt    = 1'b1;
        head_nxt  = '0;
        count_nxt = init_n;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_opcode;
      idx_r <= in_free_index;
    end
    if (cmd.accept) begin
      sweep_r <= '0;
    end else if (cmd.sweep_we) begin
      sweep_r <= sweep_inc;
    end
    if (cmd.commit) begin
      ok_r   <= ok_nxt;
      bidx_r <= bidx_nxt;
      off_r  <= off_nxt;
      fcnt_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_op_ok       = ok_r;
  assign out_block_index = bidx_r;
  assign out_byte_offset = off_r;
  assign out_free_count  = fcnt_r;

`ifndef ASSERT_OFF
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !out_valid_r || !out_stall)
    else $error("result overwrote a pending transfer");
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("result not presented after commit");
  a_alloc_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && op_r == fbfa_pkg::OP_ALLOC && count_r != '0
      |=> count_r == $past(count_r) - CW'(1))
    else $error("alloc did not decrement free count");
  a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep_we |-> sweep_r < init_n)
    else $error("init sweep past block count");
`endif

endmodule

FILE: rtl/fixed_block_free_list_allocator_top.sv
// top level of the fixed size block allocator with free list and apb registers
// alloc, free and unknown opcodes go idle, fin, then register the result when the output is free
// init first sweeps n = min(block_count, 256) entries, one next table write per cycle
// in_stall is high outside idle, so a new item is taken only after the last has committed
// reset: head and free count clear to 0, block_count 256, block_bytes 8; table undefined
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [fbfa_pkg::IDX_W-1:0]    in_free_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_op_ok,
  output logic [fbfa_pkg::IDX_W-1:0]    out_block_index,
  output logic [fbfa_pkg::OFF_W-1:0]    out_byte_offset,
  output logic [fbfa_pkg::CNT_W-1:0]    out_free_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbfa_pkg::ADDR_W-1:0]   paddr,
  input  logic [fbfa_pkg::CFG_W-1:0]    pwdata,
  output logic [fbfa_pkg::CFG_W-1:0]    prdata,
  output logic                          pready
);

  logic [fbfa_pkg::CNT_W-1:0] block_count_r;
  logic [fbfa_pkg::BB_W-1:0]  block_bytes_r;
  logic                       cfg_we;
  fbfa_pkg::cmd_t             cmd;
  fbfa_pkg::status_t          status;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // register select is paddr[2]: block_count at 0, block_bytes at 4
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= fbfa_pkg::CNT_W'(fbfa_pkg::MAX_BLOCKS);
      block_bytes_r <= fbfa_pkg::BB_W'(8);
    end else if (cfg_we) begin
      if (paddr[2]) begin
        block_bytes_r <= pwdata[fbfa_pkg::BB_W-1:0];
      end else begin
        block_count_r <= pwdata[fbfa_pkg::CNT_W-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? fbfa_pkg::CFG_W'(block_bytes_r)
                           : fbfa_pkg::CFG_W'(block_count_r);

  fbfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .status    (status),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  fbfa_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_opcode       (in_opcode),
    .in_free_index   (in_free_index),
    .block_count     (block_count_r),
    .block_bytes     (block_bytes_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_op_ok       (out_op_ok),
    .out_block_index (out_block_index),
    .out_byte_offset (out_byte_offset),
    .out_free_count  (out_free_count)
  );

endmodule
